>>> sv/replsel_pkg.sv
package replsel_pkg;

   localparam int HEAP_DEPTH = 1024;
   localparam int ADDR_W = $clog2(HEAP_DEPTH);
   localparam int CNT_W = ADDR_W + 1;
   localparam int CAP_W = 11;
   localparam int KEY_W = 32;
   localparam int RUN_W = 16;
   localparam logic [CAP_W-1:0] CAP_RESET = 11'd750;

   typedef enum logic [4:0] {
      S_IDLE,
      S_PRE,
      S_RUN_START,
      S_BUILD_STEP,
      S_BUILD_LOAD,
      S_DISPATCH,
      S_FILL_MOVE,
      S_FILL_UP,
      S_FILL_PARENT,
      S_STEADY_TOP,
      S_STEADY_LAST,
      S_DRAIN_TOP,
      S_DRAIN_LAST,
      S_DRAIN_MOVE,
      S_SD_TEST,
      S_SD_LEFT,
      S_SD_RIGHT,
      S_POST,
      S_FINISH
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_RUN_START,
      OP_BUILD_STEP,
      OP_BUILD_LOAD,
      OP_FILL_START,
      OP_FILL_MOVE,
      OP_FILL_UP_ROOT,
      OP_FILL_READ_PARENT,
      OP_FILL_PARENT,
      OP_READ_TOP,
      OP_STEADY_TOP,
      OP_STEADY_LAST,
      OP_DRAIN_EMPTY,
      OP_DRAIN_TOP,
      OP_DRAIN_LAST,
      OP_DRAIN_MOVE,
      OP_SD_TEST,
      OP_SD_LEFT,
      OP_SD_RIGHT,
      OP_POST,
      OP_FINISH
   } op_type;

   typedef struct packed {
      logic pre_run;
      logic fill_push;
      logic mode;
      logic active_zero;
      logic parked_nz;
      logic build_zero;
      logic pos_zero;
      logic v_lt_rd;
      logic sd_stop;
      logic has_right;
      logic rd_lt_x;
      logic pick_lt_x;
      logic out_free;
   } status_type;

endpackage

>>> sv/replacement_selection_runs.sv
// Replacement-selection run generator. Pushes (mode 0) first fill a min-heap up to
// heap_capacity keys with no value out, then each push returns the heap minimum and
// either replaces it with the new key or parks the key for the next run; drains (mode 1)
// pop the remaining keys one per transaction. Every input transaction gives exactly one
// result transaction. One transaction is processed at a time, and the heap lives in a
// single-port-read RAM, so each heap level costs a read. A steady push or drain sifts a
// key down the heap level by level, and a fill push lets the new key rise level by level,
// with a move of a parked key first when one must step aside. A push or drain that ends a run
// also rebuilds the heap from the parked keys, sifting down each of half of those keys.
// A finished result waits in an output register while the next transaction is taken; a
// result that is still stalled there holds the following one back.
module replacement_selection_runs (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_mode,
   input  logic signed [replsel_pkg::KEY_W-1:0]   req_in_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_out_valid,
   output logic signed [replsel_pkg::KEY_W-1:0]   rsp_out_value,
   output logic                                   rsp_run_start,
   output logic [replsel_pkg::RUN_W-1:0]          rsp_run_number,
   output logic                                   rsp_all_empty,
   input  logic                                   csr_wr_en,
   input  logic [replsel_pkg::CAP_W-1:0]          csr_wr_data
);
   import replsel_pkg::*;

   op_type     op;
   status_type status;

   replsel_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status   (status),
      .op       (op)
   );

   replsel_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .op            (op),
      .status        (status),
      .req_mode      (req_mode),
      .req_in_value  (req_in_value),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_valid (rsp_out_valid),
      .rsp_out_value (rsp_out_value),
      .rsp_run_start (rsp_run_start),
      .rsp_run_number(rsp_run_number),
      .rsp_all_empty (rsp_all_empty)
   );

endmodule

>>> sv/replsel_ram.sv
module replsel_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> sv/replsel_ctrl.sv
module replsel_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  replsel_pkg::status_type status,
   output replsel_pkg::op_type    op
);
   import replsel_pkg::*;

   state_type state_ff, state_in;
   logic      pre_ff, pre_in;
   logic      sift_build_ff, sift_build_in;
   state_type sift_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pre_ff        <= 1'b0;
         sift_build_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pre_ff        <= pre_in;
         sift_build_ff <= sift_build_in;
      end
   end

   // A sift-down returns either to the heap build loop or to the end of the item.
   assign sift_done = sift_build_ff ? S_BUILD_STEP : S_POST;

   always_comb begin
      state_in      = state_ff;
      pre_in        = pre_ff;
      sift_build_in = sift_build_ff;
      op            = OP_NONE;
      req_stall     = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op       = OP_ACCEPT;
               state_in = S_PRE;
            end
         end
         S_PRE: begin
            if (status.pre_run) begin
               pre_in   = 1'b1;
               state_in = S_RUN_START;
            end else begin
               state_in = S_DISPATCH;
            end
         end
         S_RUN_START: begin
            op       = OP_RUN_START;
            state_in = S_BUILD_STEP;
         end
         S_BUILD_STEP: begin
            if (status.build_zero) begin
               state_in = pre_ff ? S_DISPATCH : S_FINISH;
            end else begin
               op       = OP_BUILD_STEP;
               state_in = S_BUILD_LOAD;
            end
         end
         S_BUILD_LOAD: begin
            op            = OP_BUILD_LOAD;
            sift_build_in = 1'b1;
            state_in      = S_SD_TEST;
         end
         S_DISPATCH: begin
            sift_build_in = 1'b0;
            if (status.fill_push) begin
               op       = OP_FILL_START;
               state_in = status.parked_nz ? S_FILL_MOVE : S_FILL_UP;
            end else if (!status.mode) begin
               op       = OP_READ_TOP;
               state_in = S_STEADY_TOP;
            end else if (status.active_zero) begin
               op       = OP_DRAIN_EMPTY;
               state_in = S_FINISH;
            end else begin
               op       = OP_READ_TOP;
               state_in = S_DRAIN_TOP;
            end
         end
         S_FILL_MOVE: begin
            op       = OP_FILL_MOVE;
            state_in = S_FILL_UP;
         end
         S_FILL_UP: begin
            if (status.pos_zero) begin
               op       = OP_FILL_UP_ROOT;
               state_in = S_FINISH;
            end else begin
               op       = OP_FILL_READ_PARENT;
               state_in = S_FILL_PARENT;
            end
         end
         S_FILL_PARENT: begin
            op       = OP_FILL_PARENT;
            state_in = status.v_lt_rd ? S_FILL_UP : S_FINISH;
         end
         S_STEADY_TOP: begin
            op       = OP_STEADY_TOP;
            state_in = status.v_lt_rd ? S_STEADY_LAST : S_SD_TEST;
         end
         S_STEADY_LAST: begin
            op       = OP_STEADY_LAST;
            state_in = S_SD_TEST;
         end
         S_DRAIN_TOP: begin
            op       = OP_DRAIN_TOP;
            state_in = S_DRAIN_LAST;
         end
         S_DRAIN_LAST: begin
            op       = OP_DRAIN_LAST;
            state_in = status.parked_nz ? S_DRAIN_MOVE : S_SD_TEST;
         end
         S_DRAIN_MOVE: begin
            op       = OP_DRAIN_MOVE;
            state_in = S_SD_TEST;
         end
         S_SD_TEST: begin
            op       = OP_SD_TEST;
            state_in = status.sd_stop ? sift_done : S_SD_LEFT;
         end
         S_SD_LEFT: begin
            op = OP_SD_LEFT;
            if (status.has_right) begin
               state_in = S_SD_RIGHT;
            end else begin
               state_in = status.rd_lt_x ? S_SD_TEST : sift_done;
            end
         end
         S_SD_RIGHT: begin
            op       = OP_SD_RIGHT;
            state_in = status.pick_lt_x ? S_SD_TEST : sift_done;
         end
         S_POST: begin
            op = OP_POST;
            if (status.pre_run) begin
               pre_in   = 1'b0;
               state_in = S_RUN_START;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            op = OP_FINISH;
            if (status.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

>>> sv/replsel_dp.sv
module replsel_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  replsel_pkg::op_type                    op,
   output replsel_pkg::status_type                status,
   input  logic                                   req_mode,
   input  logic signed [replsel_pkg::KEY_W-1:0]   req_in_value,
   input  logic                                   csr_wr_en,
   input  logic [replsel_pkg::CAP_W-1:0]          csr_wr_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_out_valid,
   output logic signed [replsel_pkg::KEY_W-1:0]   rsp_out_value,
   output logic                                   rsp_run_start,
   output logic [replsel_pkg::RUN_W-1:0]          rsp_run_number,
   output logic                                   rsp_all_empty
);
   import replsel_pkg::*;

   logic [CAP_W-1:0]        cap_ff, cap_in;
   logic                    mode_ff, mode_in;
   logic signed [KEY_W-1:0] val_ff, val_in;
   logic [CNT_W-1:0]        fill_ff, fill_in;
   logic [CNT_W-1:0]        active_ff, active_in;
   logic [CNT_W-1:0]        parked_ff, parked_in;
   logic [RUN_W-1:0]        run_ff, run_in;
   logic                    nrs_ff, nrs_in;
   logic [ADDR_W-1:0]       pos_ff, pos_in;
   logic signed [KEY_W-1:0] x_ff, x_in;
   logic signed [KEY_W-1:0] left_ff, left_in;
   logic [CNT_W-1:0]        build_ff, build_in;
   logic                    res_valid_ff, res_valid_in;
   logic signed [KEY_W-1:0] res_value_ff, res_value_in;
   logic                    res_rs_ff, res_rs_in;
   logic                    res_empty_ff, res_empty_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_out_valid_ff, rsp_out_valid_in;
   logic signed [KEY_W-1:0] rsp_out_value_ff, rsp_out_value_in;
   logic                    rsp_run_start_ff, rsp_run_start_in;
   logic [RUN_W-1:0]        rsp_run_number_ff, rsp_run_number_in;
   logic                    rsp_all_empty_ff, rsp_all_empty_in;

   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic [KEY_W-1:0]        wr_data;
   logic [ADDR_W-1:0]       rd_addr;
   logic [KEY_W-1:0]        rd_data;

   logic [CNT_W-1:0]        eff_cap;
   logic [CNT_W-1:0]        last;
   logic [CNT_W-1:0]        move_src;
   logic [CNT_W-1:0]        tail;
   logic [CNT_W-1:0]        left_w;
   logic [CNT_W-1:0]        right_w;
   logic [ADDR_W-1:0]       pos_m1;
   logic [ADDR_W-1:0]       parent_a;
   logic [CNT_W-1:0]        build_m1;
   logic signed [KEY_W-1:0] rd_s;
   logic                    right_wins;
   logic signed [KEY_W-1:0] pick;
   logic [ADDR_W-1:0]       pick_a;
   logic                    active_zero;
   logic                    fill_below;

   replsel_ram #(
      .WIDTH(KEY_W),
      .DEPTH(HEAP_DEPTH)
   ) u_heap (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CNT_W'(1);
      end else if (int'(cap_ff) > HEAP_DEPTH) begin
         eff_cap = CNT_W'(HEAP_DEPTH);
      end else begin
         eff_cap = CNT_W'(cap_ff);
      end
   end

   assign last       = active_ff - CNT_W'(1);
   assign move_src   = last + parked_ff;
   assign tail       = active_ff + parked_ff;
   assign left_w     = {pos_ff, 1'b1};
   assign right_w    = {pos_ff, 1'b0} + CNT_W'(2);
   assign pos_m1     = pos_ff - ADDR_W'(1);
   assign parent_a   = {1'b0, pos_m1[ADDR_W-1:1]};
   assign build_m1   = build_ff - CNT_W'(1);
   assign rd_s       = signed'(rd_data);
   assign right_wins = rd_s < left_ff;
   assign pick       = right_wins ? rd_s : left_ff;
   assign pick_a     = right_wins ? right_w[ADDR_W-1:0] : left_w[ADDR_W-1:0];
   assign active_zero = (active_ff == '0);
   assign fill_below  = (fill_ff < eff_cap);

   always_comb begin
      status.pre_run     = active_zero && (parked_ff != '0);
      status.fill_push   = !mode_ff && (fill_below || active_zero);
      status.mode        = mode_ff;
      status.active_zero = active_zero;
      status.parked_nz   = (parked_ff != '0);
      status.build_zero  = (build_ff == '0);
      status.pos_zero    = (pos_ff == '0);
      status.v_lt_rd     = val_ff < rd_s;
      status.sd_stop     = active_zero || ({1'b0, pos_ff} >= (active_ff >> 1));
      status.has_right   = right_w < active_ff;
      status.rd_lt_x     = rd_s < x_ff;
      status.pick_lt_x   = pick < x_ff;
      status.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      cap_in            = csr_wr_en ? csr_wr_data : cap_ff;
      mode_in           = mode_ff;
      val_in            = val_ff;
      fill_in           = fill_ff;
      active_in         = active_ff;
      parked_in         = parked_ff;
      run_in            = run_ff;
      nrs_in            = nrs_ff;
      pos_in            = pos_ff;
      x_in              = x_ff;
      left_in           = left_ff;
      build_in          = build_ff;
      res_valid_in      = res_valid_ff;
      res_value_in      = res_value_ff;
      res_rs_in         = res_rs_ff;
      res_empty_in      = res_empty_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_out_valid_in  = rsp_out_valid_ff;
      rsp_out_value_in  = rsp_out_value_ff;
      rsp_run_start_in  = rsp_run_start_ff;
      rsp_run_number_in = rsp_run_number_ff;
      rsp_all_empty_in  = rsp_all_empty_ff;
      wr_en             = 1'b0;
      wr_addr           = pos_ff;
      wr_data           = x_ff;
      rd_addr           = '0;
      case (op)
         OP_ACCEPT: begin
            mode_in      = req_mode;
            val_in       = req_in_value;
            res_valid_in = 1'b0;
            res_value_in = '0;
            res_rs_in    = 1'b0;
            res_empty_in = 1'b0;
         end
         OP_RUN_START: begin
            active_in = parked_ff;
            parked_in = '0;
            run_in    = run_ff + RUN_W'(1);
            nrs_in    = 1'b1;
            build_in  = parked_ff >> 1;
         end
         OP_BUILD_STEP: begin
            build_in = build_m1;
            pos_in   = build_m1[ADDR_W-1:0];
            rd_addr  = build_m1[ADDR_W-1:0];
         end
         OP_BUILD_LOAD: begin
            x_in = rd_s;
         end
         OP_FILL_START: begin
            rd_addr = active_ff[ADDR_W-1:0];
            pos_in  = active_ff[ADDR_W-1:0];
         end
         OP_FILL_MOVE: begin
            // The first parked key steps aside to free the new leaf slot.
            wr_en   = 1'b1;
            wr_addr = tail[ADDR_W-1:0];
            wr_data = rd_data;
         end
         OP_FILL_UP_ROOT: begin
            wr_en     = 1'b1;
            wr_data   = val_ff;
            active_in = active_ff + CNT_W'(1);
            if (fill_below) begin
               fill_in = fill_ff + CNT_W'(1);
            end
         end
         OP_FILL_READ_PARENT: begin
            rd_addr = parent_a;
         end
         OP_FILL_PARENT: begin
            wr_en = 1'b1;
            if (val_ff < rd_s) begin
               wr_data = rd_data;
               pos_in  = parent_a;
            end else begin
               wr_data   = val_ff;
               active_in = active_ff + CNT_W'(1);
               if (fill_below) begin
                  fill_in = fill_ff + CNT_W'(1);
               end
            end
         end
         OP_READ_TOP: begin
            rd_addr = '0;
         end
         OP_STEADY_TOP: begin
            res_valid_in = 1'b1;
            res_value_in = rd_s;
            res_rs_in    = nrs_ff;
            nrs_in       = 1'b0;
            rd_addr      = last[ADDR_W-1:0];
            x_in         = val_ff;
            pos_in       = '0;
         end
         OP_STEADY_LAST: begin
            // The smaller key is parked in the slot the active heap gives up.
            x_in      = rd_s;
            wr_en     = 1'b1;
            wr_addr   = last[ADDR_W-1:0];
            wr_data   = val_ff;
            active_in = last;
            parked_in = parked_ff + CNT_W'(1);
            pos_in    = '0;
         end
         OP_DRAIN_EMPTY: begin
            res_empty_in = 1'b1;
            fill_in      = '0;
         end
         OP_DRAIN_TOP: begin
            res_valid_in = 1'b1;
            res_value_in = rd_s;
            res_rs_in    = nrs_ff;
            nrs_in       = 1'b0;
            rd_addr      = last[ADDR_W-1:0];
         end
         OP_DRAIN_LAST: begin
            x_in    = rd_s;
            pos_in  = '0;
            rd_addr = move_src[ADDR_W-1:0];
            if (parked_ff == '0) begin
               active_in = last;
            end
         end
         OP_DRAIN_MOVE: begin
            wr_en     = 1'b1;
            wr_addr   = last[ADDR_W-1:0];
            wr_data   = rd_data;
            active_in = last;
         end
         OP_SD_TEST: begin
            if (!active_zero) begin
               if ({1'b0, pos_ff} >= (active_ff >> 1)) begin
                  wr_en = 1'b1;
               end else begin
                  rd_addr = left_w[ADDR_W-1:0];
               end
            end
         end
         OP_SD_LEFT: begin
            left_in = rd_s;
            rd_addr = right_w[ADDR_W-1:0];
            if (!(right_w < active_ff)) begin
               wr_en = 1'b1;
               if (rd_s < x_ff) begin
                  wr_data = rd_data;
                  pos_in  = left_w[ADDR_W-1:0];
               end
            end
         end
         OP_SD_RIGHT: begin
            wr_en = 1'b1;
            if (pick < x_ff) begin
               wr_data = pick;
               pos_in  = pick_a;
            end
         end
         OP_POST: begin
            // The last stored key is gone: the next push starts a new fill and run.
            if (active_zero && (parked_ff == '0)) begin
               fill_in = '0;
               run_in  = run_ff + RUN_W'(1);
               nrs_in  = 1'b1;
            end
         end
         OP_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_out_valid_in  = res_valid_ff;
               rsp_out_value_in  = res_value_ff;
               rsp_run_start_in  = res_rs_ff;
               rsp_run_number_in = run_ff;
               rsp_all_empty_in  = res_empty_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         fill_ff      <= '0;
         active_ff    <= '0;
         parked_ff    <= '0;
         run_ff       <= '0;
         nrs_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         fill_ff      <= fill_in;
         active_ff    <= active_in;
         parked_ff    <= parked_in;
         run_ff       <= run_in;
         nrs_ff       <= nrs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff           <= mode_in;
      val_ff            <= val_in;
      pos_ff            <= pos_in;
      x_ff              <= x_in;
      left_ff           <= left_in;
      build_ff          <= build_in;
      res_valid_ff      <= res_valid_in;
      res_value_ff      <= res_value_in;
      res_rs_ff         <= res_rs_in;
      res_empty_ff      <= res_empty_in;
      rsp_out_valid_ff  <= rsp_out_valid_in;
      rsp_out_value_ff  <= rsp_out_value_in;
      rsp_run_start_ff  <= rsp_run_start_in;
      rsp_run_number_ff <= rsp_run_number_in;
      rsp_all_empty_ff  <= rsp_all_empty_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_valid  = rsp_out_valid_ff;
   assign rsp_out_value  = rsp_out_value_ff;
   assign rsp_run_start  = rsp_run_start_ff;
   assign rsp_run_number = rsp_run_number_ff;
   assign rsp_all_empty  = rsp_all_empty_ff;

   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      (32'(active_ff) + 32'(parked_ff)) <= HEAP_DEPTH)
      else $error("Heap and parked area exceed the store.");

   a_start_has_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_run_start_ff) |-> rsp_out_valid_ff)
      else $error("Run start flagged on a transaction without a value.");

   a_empty_no_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_all_empty_ff) |-> !rsp_out_valid_ff)
      else $error("Empty drain reported together with a value.");

endmodule
